// File: rtl/core/tat_pkg.sv
// types and constants shared by the typed adjacency table
`default_nettype none

package tat_pkg;

  localparam int NODE_W = 10;
  localparam int TYPE_W = 4;

  // request kinds
  localparam logic [1:0] MODE_ADD_ANY     = 2'd0;
  localparam logic [1:0] MODE_ADD_TYPED   = 2'd1;
  localparam logic [1:0] MODE_QUERY_TYPED = 2'd2;
  localparam logic [1:0] MODE_QUERY_ANY   = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [TYPE_W-1:0] type_a;
    logic [TYPE_W-1:0] type_b;
  } req_t;

  typedef struct packed {
    logic found;
    logic added;
    logic overflow;
  } rsp_t;

  // one neighbour list entry
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [TYPE_W-1:0] link_type;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_A,
    ST_CNT_B,
    ST_CNT_C,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_DRAIN,
    ST_DECIDE,
    ST_WR1,
    ST_WR2
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/tat_ram.sv
// generic single-port ram with registered read
`default_nettype none

module tat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/typed_adjacency_table.sv
// typed adjacency table: per-node neighbour lists with duplicate check
// takes one item at a time: reads both counts, scans node_a's then node_b's list, then
//   registers the result, held while out_stall is set; a successful add then appends to both lists
// the list memory scans one entry a cycle
// reset: a clearing pass zeroes the counts; list entries are not cleared
`default_nettype none

module typed_adjacency_table #(
  parameter int NODES = 1024,
  parameter int SLOTS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire tat_pkg::req_t in_data,
  output      logic          out_valid,
  input  wire logic          out_stall,
  output      tat_pkg::rsp_t out_data
);

  import tat_pkg::*;

  // node address, slot index and count widths
  localparam int NW       = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW       = $clog2(SLOTS + 1);
  localparam int LW       = NW + SW;
  localparam int LDEPTH   = NODES << SW;

  // state and request registers
  state_t        state_r, state_nxt;
  req_t          req_r, req_nxt;
  logic [NW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] j_r, j_nxt;

  // scan pipeline: a read was issued last cycle, and from which list
  logic rd_v_r, rd_v_nxt;
  logic rd_b_r, rd_b_nxt;
  logic any_a_r, any_a_nxt;
  logic any_b_r, any_b_nxt;
  logic typed_r, typed_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  rsp_t out_data_r, out_data_nxt;

  // memory ports
  logic          cnt_we;
  logic [NW-1:0] cnt_addr;
  logic [CW-1:0] cnt_wdata;
  logic [CW-1:0] cnt_rdata;
  logic          nb_we;
  logic [LW-1:0] nb_addr;
  entry_t        nb_wdata;
  entry_t        nb_rdata;

  // decision terms
  logic          self_link;
  logic          a_ok;
  logic          b_ok;
  logic          found;
  logic          want_add;
  logic          ovf;
  logic [CW:0]   need_a;
  logic [CW-1:0] cnt2;
  logic          hit_node;
  logic          hit_type;
  logic          in_xfer;
  logic          out_free;

  // link counts, one per node
  tat_ram #(
    .WIDTH (CW),
    .DEPTH (NODES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  // neighbour entries, SLOTS-aligned rows per node
  tat_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (LDEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (nb_we),
    .addr  (nb_addr),
    .wdata (nb_wdata),
    .rdata (nb_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // out-of-range nodes read as empty lists
  assign a_ok      = int'(req_r.node_a) < NODES;
  assign b_ok      = int'(req_r.node_b) < NODES;
  assign self_link = (req_r.node_a == req_r.node_b);

  // compare the entry that returns this cycle against the list's target
  assign hit_node = rd_b_r ? (nb_rdata.node == req_r.node_a)
                           : (nb_rdata.node == req_r.node_b);
  assign hit_type = rd_b_r ? (nb_rdata.link_type == req_r.type_b)
                           : (nb_rdata.link_type == req_r.type_a);

  // found by the rule of the request kind
  always_comb begin
    unique case (req_r.mode)
      MODE_ADD_ANY:   found = any_a_r || any_b_r;
      MODE_QUERY_ANY: found = any_a_r;
      default:        found = typed_r;
    endcase
  end

  assign want_add = ((req_r.mode == MODE_ADD_ANY) || (req_r.mode == MODE_ADD_TYPED))
                    && !found;
  assign need_a   = self_link ? ({1'b0, cnt_a_r} + (CW+1)'(2))
                              : ({1'b0, cnt_a_r} + (CW+1)'(1));
  assign ovf      = !a_ok || !b_ok
                    || (need_a > (CW+1)'(SLOTS))
                    || (!self_link && (({1'b0, cnt_b_r} + (CW+1)'(1)) > (CW+1)'(SLOTS)));

  // second append: next slot of node_a for a self-link, else node_b's tail
  assign cnt2 = self_link ? (cnt_a_r + CW'(1)) : cnt_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cnt_a_r    <= cnt_a_nxt;
    cnt_b_r    <= cnt_b_nxt;
    j_r        <= j_nxt;
    rd_b_r     <= rd_b_nxt;
    any_a_r    <= any_a_nxt;
    any_b_r    <= any_b_nxt;
    typed_r    <= typed_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    clr_nxt       = clr_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    j_nxt         = j_r;
    rd_v_nxt      = 1'b0;
    rd_b_nxt      = rd_b_r;
    any_a_nxt     = any_a_r;
    any_b_nxt     = any_b_r;
    typed_nxt     = typed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    cnt_we    = 1'b0;
    cnt_addr  = NW'(req_r.node_a);
    cnt_wdata = '0;
    nb_we     = 1'b0;
    nb_addr   = {NW'(req_r.node_a), SW'(j_r)};
    nb_wdata  = '{node: req_r.node_b, link_type: req_r.type_a};

    // fold in the entry read last cycle
    if (rd_v_r) begin
      if (hit_node && !rd_b_r) any_a_nxt = 1'b1;
      if (hit_node && rd_b_r)  any_b_nxt = 1'b1;
      if (hit_node && hit_type) typed_nxt = 1'b1;
    end

    unique case (state_r)
      ST_CLEAR: begin
        // zero every count after reset
        cnt_we   = 1'b1;
        cnt_addr = clr_r;
        clr_nxt  = clr_r + NW'(1);
        if (clr_r == NW'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_addr = NW'(in_data.node_a);
        if (in_xfer) begin
          req_nxt   = in_data;
          any_a_nxt = 1'b0;
          any_b_nxt = 1'b0;
          typed_nxt = 1'b0;
          state_nxt = ST_CNT_A;
        end
      end
      ST_CNT_A: begin
        cnt_addr  = NW'(req_r.node_b);
        state_nxt = ST_CNT_B;
      end
      ST_CNT_B: begin
        // node_b's count, read in the previous cycle; node_a's is read now
        cnt_b_nxt = b_ok ? cnt_rdata : '0;
        state_nxt = ST_CNT_C;
      end
      ST_CNT_C: begin
        cnt_a_nxt = a_ok ? cnt_rdata : '0;
        j_nxt     = '0;
        state_nxt = ST_SCAN_A;
      end
      ST_SCAN_A: begin
        // one entry of node_a's list per cycle
        if (j_r < cnt_a_r) begin
          nb_addr  = {NW'(req_r.node_a), SW'(j_r)};
          rd_v_nxt = 1'b1;
          rd_b_nxt = 1'b0;
          j_nxt    = j_r + CW'(1);
        end else begin
          j_nxt     = '0;
          state_nxt = ST_SCAN_B;
        end
      end
      ST_SCAN_B: begin
        if (j_r < cnt_b_r) begin
          nb_addr  = {NW'(req_r.node_b), SW'(j_r)};
          rd_v_nxt = 1'b1;
          rd_b_nxt = 1'b1;
          j_nxt    = j_r + CW'(1);
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // the last compare has already landed in the flags
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.found    = found;
          out_data_nxt.added    = want_add && !ovf;
          out_data_nxt.overflow = want_add && ovf;
          state_nxt             = (want_add && !ovf) ? ST_WR1 : ST_IDLE;
        end
      end
      ST_WR1: begin
        // (node_b, type_a) at the tail of node_a's list
        nb_we     = 1'b1;
        nb_addr   = {NW'(req_r.node_a), SW'(cnt_a_r)};
        nb_wdata  = '{node: req_r.node_b, link_type: req_r.type_a};
        cnt_we    = 1'b1;
        cnt_addr  = NW'(req_r.node_a);
        cnt_wdata = cnt_a_r + CW'(1);
        state_nxt = ST_WR2;
      end
      ST_WR2: begin
        // (node_a, type_b) at the tail of node_b's list
        nb_we     = 1'b1;
        nb_addr   = {NW'(req_r.node_b), SW'(cnt2)};
        nb_wdata  = '{node: req_r.node_a, link_type: req_r.type_b};
        cnt_we    = 1'b1;
        cnt_addr  = NW'(req_r.node_b);
        cnt_wdata = cnt2 + CW'(1);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // a result never claims both a hit and an append, nor an append and a refusal
  a_rsp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.found && out_data_r.added)
                    && !(out_data_r.added && out_data_r.overflow))
    else $error("inconsistent result flags");

  // queries leave the lists alone
  a_query_no_add: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DECIDE) && out_free
     && ((req_r.mode == MODE_QUERY_TYPED) || (req_r.mode == MODE_QUERY_ANY)))
    |=> !out_data_r.added && !out_data_r.overflow)
    else $error("query reported an add");

  // appends stay inside the node's row
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR1) |-> (int'(cnt_a_r) < SLOTS) && (int'(cnt2) < SLOTS))
    else $error("append beyond list capacity");

  // one item at a time: busy right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("second item taken while busy");

endmodule

`default_nettype wire

// File: tb/tat_link_tracker_pkg.sv
// scoreboard class that mirrors the neighbour lists and checks each response
package tat_link_tracker_pkg;

  import tat_pkg::*;

  localparam int TB_NODES = 1024;
  localparam int TB_SLOTS = 16;

  // a request together with the response it should produce
  typedef struct packed {
    req_t req;
    rsp_t answer;
  } outcome_t;

  class link_tracker;

    entry_t      lists [TB_NODES][TB_SLOTS];
    int unsigned fill [TB_NODES];
    outcome_t    pending_answers [$];
    int          mismatch_count;
    int          requests_seen;
    int          links_added;
    int          links_found;
    int          adds_refused;

    function new();
      mismatch_count = 0;
      requests_seen  = 0;
      links_added    = 0;
      links_found    = 0;
      adds_refused   = 0;
      foreach (fill[n]) fill[n] = 0;
    endfunction

    function int outstanding();
      return pending_answers.size();
    endfunction

    // list of node n names node m, with link type t when typed
    function bit list_names(int unsigned n, logic [NODE_W-1:0] m,
                            logic [TYPE_W-1:0] t, bit typed);
      for (int j = 0; j < fill[n]; j++) begin
        if (lists[n][j].node == m && (!typed || lists[n][j].link_type == t))
          return 1'b1;
      end
      return 1'b0;
    endfunction

    function void append_entry(int unsigned n, logic [NODE_W-1:0] m,
                               logic [TYPE_W-1:0] t);
      lists[n][fill[n]].node      = m;
      lists[n][fill[n]].link_type = t;
      fill[n]++;
    endfunction

    // work out the response to an accepted request and update the lists
    function void note_request(req_t r);
      outcome_t    o;
      int unsigned a;
      int unsigned b;
      a = r.node_a;
      b = r.node_b;
      o.req    = r;
      o.answer = '0;
      case (r.mode)
        MODE_ADD_ANY:
          o.answer.found = list_names(a, r.node_b, '0, 1'b0) ||
                           list_names(b, r.node_a, '0, 1'b0);
        MODE_QUERY_ANY:
          o.answer.found = list_names(a, r.node_b, '0, 1'b0);
        default:
          o.answer.found = list_names(a, r.node_b, r.type_a, 1'b1) ||
                           list_names(b, r.node_a, r.type_b, 1'b1);
      endcase
      if ((r.mode == MODE_ADD_ANY || r.mode == MODE_ADD_TYPED) && !o.answer.found) begin
        if (a == b) begin
          if (fill[a] + 2 > TB_SLOTS) begin
            o.answer.overflow = 1'b1;
          end else begin
            append_entry(a, r.node_a, r.type_a);
            append_entry(a, r.node_a, r.type_b);
            o.answer.added = 1'b1;
          end
        end else if (fill[a] + 1 > TB_SLOTS || fill[b] + 1 > TB_SLOTS) begin
          o.answer.overflow = 1'b1;
        end else begin
          append_entry(a, r.node_b, r.type_a);
          append_entry(b, r.node_a, r.type_b);
          o.answer.added = 1'b1;
        end
      end
      requests_seen++;
      if (o.answer.found) links_found++;
      if (o.answer.added) links_added++;
      if (o.answer.overflow) adds_refused++;
      pending_answers.push_back(o);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
    endtask

    task check_response(rsp_t got);
      outcome_t o;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("response %b with no request outstanding", got));
        return;
      end
      o = pending_answers.pop_front();
      if (got.found !== o.answer.found)
        report_mismatch($sformatf("found %b, wanted %b for request %h",
                                  got.found, o.answer.found, o.req));
      if (got.added !== o.answer.added)
        report_mismatch($sformatf("added %b, wanted %b for request %h",
                                  got.added, o.answer.added, o.req));
      if (got.overflow !== o.answer.overflow)
        report_mismatch($sformatf("overflow %b, wanted %b for request %h",
                                  got.overflow, o.answer.overflow, o.req));
    endtask

  endclass

endpackage

// File: tb/typed_adjacency_table_tb.sv
// testbench for the typed adjacency table: directed corner cases then pooled random requests
module typed_adjacency_table_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tat_pkg::*;
  import tat_link_tracker_pkg::*;

  localparam int NODE_MAX       = TB_NODES - 1;
  localparam int TYPE_MAX       = (1 << TYPE_W) - 1;
  localparam int RANDOM_ITEMS   = 900;
  localparam int SEGMENT        = 100;    // requests per node pool
  localparam int POOL           = 6;      // nodes per pool, so lists fill and overflow
  localparam int CALM_TAIL      = 150;    // last requests run with no idling
  localparam int HOLD_CYCLES    = 200;    // long receiver hold-off
  localparam int DRAIN_CYCLES   = 2 * TB_SLOTS + 20;
  // clearing pass after reset plus a hold-off, with margin
  localparam int WATCHDOG_LIMIT = 4 * (TB_NODES + HOLD_CYCLES);

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  link_tracker tracker;
  logic [1:0]  mode_menu [4];
  bit          tx_idling;
  bit          rx_idling;
  bit          hold_request;
  int          quiet_cycles = 0;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typed_adjacency_table #(
    .NODES (TB_NODES),
    .SLOTS (TB_SLOTS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // transfers are taken from the values held just before the edge
  // the watchdog counts edges at which neither channel moves a transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_request(in_data);
    if (rst_n && out_valid && !out_stall) tracker.check_response(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: short random stall bursts, and a long hold-off on request
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic req_t make_req(logic [1:0] mode, int a, int b, int ta, int tb);
    req_t r;
    r.mode   = mode;
    r.node_a = NODE_W'(a);
    r.node_b = NODE_W'(b);
    r.type_a = TYPE_W'(ta);
    r.type_b = TYPE_W'(tb);
    return r;
  endfunction

  // most requests stay within a small pool of nodes, and each link type is half the time one of 0 to 2,
  // so duplicates hit and lists run full; a tenth roam the whole node range
  function automatic req_t rand_req(int base);
    req_t r;
    r.mode = mode_menu[$urandom_range(0, 3)];
    if ($urandom_range(0, 9) == 0) begin
      r.node_a = NODE_W'($urandom_range(0, NODE_MAX));
      r.node_b = NODE_W'($urandom_range(0, NODE_MAX));
    end else begin
      r.node_a = NODE_W'(base + $urandom_range(0, POOL - 1));
      r.node_b = NODE_W'(base + $urandom_range(0, POOL - 1));
    end
    r.type_a = TYPE_W'($urandom_range(0, 1) ? $urandom_range(0, TYPE_MAX) : $urandom_range(0, 2));
    r.type_b = TYPE_W'($urandom_range(0, 1) ? $urandom_range(0, TYPE_MAX) : $urandom_range(0, 2));
    return r;
  endfunction

  // offer one request and hold it until the transfer happens
  task automatic send_req(req_t r);
    int gap;
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int base;
    tracker      = new();
    mode_menu[0] = MODE_ADD_ANY;
    mode_menu[1] = MODE_ADD_TYPED;
    mode_menu[2] = MODE_QUERY_TYPED;
    mode_menu[3] = MODE_QUERY_ANY;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    tx_idling    = 1'b0;
    rx_idling    = 1'b0;
    hold_request = 1'b0;
    base         = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    tx_idling = 1'b1;
    rx_idling = 1'b1;

    // queries on empty lists at both ends of the node and type range
    send_req(make_req(MODE_QUERY_ANY, 0, 0, 0, 0));
    send_req(make_req(MODE_QUERY_TYPED, NODE_MAX, NODE_MAX, TYPE_MAX, TYPE_MAX));
    // first link, then repeats seen from either side and under other types
    send_req(make_req(MODE_ADD_ANY, 0, NODE_MAX, 0, TYPE_MAX));
    send_req(make_req(MODE_ADD_ANY, 0, NODE_MAX, 5, 5));
    send_req(make_req(MODE_ADD_ANY, NODE_MAX, 0, 0, 0));
    // typed add caught only by node_b's list
    send_req(make_req(MODE_ADD_TYPED, 0, NODE_MAX, 1, TYPE_MAX));
    // second link between the same pair under new types
    send_req(make_req(MODE_ADD_TYPED, 0, NODE_MAX, 1, TYPE_MAX - 1));
    send_req(make_req(MODE_QUERY_TYPED, 0, NODE_MAX, 1, 0));
    send_req(make_req(MODE_QUERY_ANY, NODE_MAX, 0, 0, 0));
    // self-link takes two slots of one list
    send_req(make_req(MODE_ADD_TYPED, 7, 7, 3, 12));
    send_req(make_req(MODE_QUERY_TYPED, 7, 7, 12, 0));
    send_req(make_req(MODE_ADD_ANY, 7, 7, 9, 9));
    // fill node 2 to two free slots with self-links, then run it full
    for (int i = 0; i < 7; i++) send_req(make_req(MODE_ADD_TYPED, 2, 2, i, i + 8));
    send_req(make_req(MODE_ADD_ANY, 2, 3, 4, 4));
    send_req(make_req(MODE_ADD_TYPED, 2, 2, TYPE_MAX, TYPE_MAX));  // needs two, one free
    send_req(make_req(MODE_ADD_ANY, 2, 4, 6, 6));                   // last slot taken
    send_req(make_req(MODE_ADD_ANY, 5, 2, 1, 1));                   // node_b's list full
    send_req(make_req(MODE_ADD_TYPED, 2, 6, 1, 1));                 // node_a's list full
    send_req(make_req(MODE_QUERY_ANY, 2, 4, 0, 0));

    // random part: a fresh node pool per segment, idling switched per segment
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % SEGMENT == 0) begin
        base      = $urandom_range(0, TB_NODES - POOL);
        tx_idling = $urandom_range(0, 3) != 0;
        rx_idling = $urandom_range(0, 3) != 0;
      end
      if (i >= RANDOM_ITEMS - CALM_TAIL) begin
        tx_idling = 1'b0;
        rx_idling = 1'b0;
      end
      // long receiver hold-offs while requests keep coming
      if (i == 200 || i == 600) hold_request = 1'b1;
      send_req(rand_req(base));
    end
    in_valid <= 1'b0;

    // wait for every response, then a little longer for stray ones
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.outstanding() != 0)
      tracker.report_mismatch($sformatf("%0d responses never arrived",
                                        tracker.outstanding()));

    $display("%0d requests checked: %0d links added, %0d already present, %0d adds refused",
             tracker.requests_seen, tracker.links_added, tracker.links_found,
             tracker.adds_refused);
    $display("directed corner cases, %0d pooled random requests, two long receiver hold-offs",
             RANDOM_ITEMS);
    if (tracker.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", tracker.mismatch_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
